// ===== hdl/mkpq_pkg.sv =====
package mkpq_pkg;

    // operation codes carried in tuser of the input word
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // register indexes
    localparam int unsigned CFG_KEY_ORDER = 0;

    // key order settings
    localparam logic ORDER_ABC = 1'b0;
    localparam logic ORDER_BCA = 1'b1;

    // width of the fill field in the result word
    localparam int unsigned FILL_BITS = 5;

    // result tuser bit positions
    localparam int unsigned USER_VALID    = 0;
    localparam int unsigned USER_OVERFLOW = 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SCMP  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_SHWR  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

// ===== hdl/mkpq_ram.sv =====
module mkpq_ram #(
    parameter int unsigned AW = 4,
    parameter int unsigned DW = 56
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mkpq_less.sv =====
module mkpq_less #(
    parameter int unsigned KEY_BITS = 16,
    parameter int unsigned TAG_BITS = 8
) (
    input  logic [TAG_BITS+3*KEY_BITS-1:0] i_x,
    input  logic [TAG_BITS+3*KEY_BITS-1:0] i_y,
    input  logic                           i_key_order,
    output logic                           o_lt
);
    import mkpq_pkg::*;

    logic signed [KEY_BITS-1:0] xa, xb, xc, ya, yb, yc;
    logic signed [KEY_BITS-1:0] x0, x1, x2, y0, y1, y2;

    // split records into their keys
    assign xa = i_x[TAG_BITS +: KEY_BITS];
    assign xb = i_x[TAG_BITS+KEY_BITS +: KEY_BITS];
    assign xc = i_x[TAG_BITS+2*KEY_BITS +: KEY_BITS];
    assign ya = i_y[TAG_BITS +: KEY_BITS];
    assign yb = i_y[TAG_BITS+KEY_BITS +: KEY_BITS];
    assign yc = i_y[TAG_BITS+2*KEY_BITS +: KEY_BITS];

    // rotate keys into comparison order
    always_comb begin
        if (i_key_order == ORDER_BCA) begin
            x0 = xb; x1 = xc; x2 = xa;
            y0 = yb; y1 = yc; y2 = ya;
        end else begin
            x0 = xa; x1 = xb; x2 = xc;
            y0 = ya; y1 = yb; y2 = yc;
        end
    end

    // lexicographic strict less
    always_comb begin
        if (x0 != y0) begin
            o_lt = x0 < y0;
        end else if (x1 != y1) begin
            o_lt = x1 < y1;
        end else begin
            o_lt = x2 < y2;
        end
    end

endmodule

// ===== hdl/multi_key_priority_queue.sv =====
// Bounded min-priority queue of records (tag plus three signed keys) held in one
// synchronous RAM. A push (tuser 0) writes the record behind the last one and returns a
// result word with the new fill; a push to a full queue is dropped and flagged as
// overflow. A pop (tuser 1) scans the held records one RAM read at a time, then closes the
// gap by moving each later record down one slot; a pop on an empty queue goes straight to
// the result. Each operation then waits until the previous result word is taken. Equal keys
// leave in push order. key_order at address 0 picks comparison A,B,C (0) or B,C,A (1) and
// is to be written only while the queue is idle; the block itself does not enforce this.
module multi_key_priority_queue #(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned KEY_BITS = 16,
    parameter int unsigned TAG_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input word: tdata = tag, key_a, key_b, key_c; tuser = op
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic [((TAG_BITS+3*KEY_BITS+7)/8)*8-1:0] i_s_tdata,
    input  logic i_s_tuser,
    // result word: tdata = out_tag, out_a, out_b, out_c, fill; tuser = out_valid, overflow
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output logic [((TAG_BITS+3*KEY_BITS+mkpq_pkg::FILL_BITS+7)/8)*8-1:0] o_m_tdata,
    output logic [1:0] o_m_tuser,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mkpq_pkg::*;

    localparam int unsigned AW  = $clog2(DEPTH);
    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned RW  = TAG_BITS + 3 * KEY_BITS;
    localparam int unsigned ODW = ((RW + FILL_BITS + 7) / 8) * 8;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_bi;
    logic [AW-1:0] r_w;
    logic [RW-1:0] r_best;
    logic [RW-1:0] r_res_rec;
    logic          r_res_valid;
    logic          r_res_ovf;
    logic          r_key_order;
    logic          r_mv;
    logic [ODW-1:0] r_mdata;
    logic [1:0]    r_muser;

    logic          we, re, lt, take, cfg_wr;
    logic [AW-1:0] waddr, raddr;
    logic [RW-1:0] wdata, rd_data;

    assign pready     = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign take       = i_s_tvalid && o_s_tready;
    assign cfg_wr     = psel && penable && pwrite;

    mkpq_ram #(.AW(AW), .DW(RW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    mkpq_less #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_less (
        .i_x         (rd_data),
        .i_y         (r_best),
        .i_key_order (r_key_order),
        .o_lt        (lt)
    );

    // ram access per state
    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = r_w;
        wdata = rd_data;
        raddr = r_i;
        case (r_state)
            S_IDLE: begin
                waddr = r_count[AW-1:0];
                wdata = i_s_tdata[RW-1:0];
                we    = take && (i_s_tuser == OP_PUSH) && (r_count < CW'(DEPTH));
            end
            S_SCAN: re = 1'b1;
            S_SHIFT: begin
                raddr = r_w + AW'(1);
                re    = (CW'(r_w) + CW'(1)) < r_count;
            end
            S_SHWR: we = 1'b1;
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_res_rec   <= '0;
                        r_res_valid <= 1'b0;
                        r_res_ovf   <= 1'b0;
                        r_i         <= '0;
                        if (i_s_tuser == OP_PUSH) begin
                            if (r_count < CW'(DEPTH)) begin
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_res_ovf <= 1'b1;
                            end
                            r_state <= S_DONE;
                        end else if (r_count == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: r_state <= S_SCMP;
                S_SCMP: begin
                    if (r_i == '0 || lt) begin
                        r_best <= rd_data;
                        r_bi   <= r_i;
                    end
                    if ((CW'(r_i) + CW'(1)) < r_count) begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_w     <= (r_i == '0 || lt) ? r_i : r_bi;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if ((CW'(r_w) + CW'(1)) < r_count) begin
                        r_state <= S_SHWR;
                    end else begin
                        r_count     <= r_count - CW'(1);
                        r_res_rec   <= r_best;
                        r_res_valid <= 1'b1;
                        r_state     <= S_DONE;
                    end
                end
                S_SHWR: begin
                    r_w     <= r_w + AW'(1);
                    r_state <= S_SHIFT;
                end
                S_DONE: begin
                    if (!r_mv || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (r_state == S_DONE && (!r_mv || i_m_tready)) begin
            r_mv    <= 1'b1;
            r_mdata <= ODW'({FILL_BITS'(r_count), r_res_rec});
            r_muser <= {r_res_ovf, r_res_valid};
        end else if (i_m_tready) begin
            r_mv <= 1'b0;
        end
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

    // key order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_order <= ORDER_ABC;
        end else if (cfg_wr && paddr[2] == 1'(CFG_KEY_ORDER)) begin
            r_key_order <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == 1'(CFG_KEY_ORDER)) ? {31'b0, r_key_order} : 32'b0;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill above depth");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[USER_VALID] && o_m_tuser[USER_OVERFLOW]))
        else $error("pop and overflow flagged together");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHWR) |-> ((CW'(r_w) + CW'(1)) < r_count))
        else $error("move beyond held records");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && !re) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not remove a record");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mkpq_pkg::*;

    localparam int DEPTH = 16;
    localparam int IN_W  = 56;
    localparam int OUT_W = 64;

    // one predicted result word
    typedef struct packed {
        logic        valid;
        logic [7:0]  tag;
        logic [15:0] ka;
        logic [15:0] kb;
        logic [15:0] kc;
        logic        ovf;
        logic [4:0]  fill;
    } t_result;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] ka;
        logic [15:0] kb;
        logic [15:0] kc;
    } t_record;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic i_s_tuser = 1'b0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic [1:0] o_m_tuser;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // model state
    t_record held_q[$];
    logic    order_sel = ORDER_ABC;
    t_result pending_q[$];
    int      errors = 0;
    bit      hold_off = 1'b0;
    bit      stall_en = 1'b1;

    multi_key_priority_queue DUT (.*);

    always #6 i_clk = ~i_clk;

    // true when x sorts strictly ahead of y
    function automatic bit sorts_ahead(t_record x, t_record y);
        logic signed [15:0] px[3], py[3];
        px = '{x.ka, x.kb, x.kc};
        py = '{y.ka, y.kb, y.kc};
        for (int i = 0; i < 3; i++) begin
            int f;
            f = (order_sel == ORDER_BCA) ? (i + 1) % 3 : i;
            if (px[f] != py[f]) return px[f] < py[f];
        end
        return 1'b0;
    endfunction

    function automatic t_result predict_op(logic op, t_record r);
        t_result res;
        int best;
        res = '0;
        if (op == OP_PUSH) begin
            if (held_q.size() >= DEPTH) res.ovf = 1'b1;
            else held_q.push_back(r);
        end else if (held_q.size() > 0) begin
            best = 0;
            for (int i = 1; i < held_q.size(); i++)
                if (sorts_ahead(held_q[i], held_q[best])) best = i;
            res.valid = 1'b1;
            res.tag = held_q[best].tag;
            res.ka = held_q[best].ka;
            res.kb = held_q[best].kb;
            res.kc = held_q[best].kc;
            held_q.delete(best);
        end
        res.fill = 5'(held_q.size());
        return res;
    endfunction

    // random gap, mostly short
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // offer one word; tvalid stays high into the next word when there is no gap
    task automatic send_word(logic op, t_record r, bit idle = 1'b1);
        int g;
        g = idle ? gap_len() : 0;
        @(negedge i_clk);
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        pending_q.push_back(predict_op(op, r));
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {r.kc, r.kb, r.ka, r.tag};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] v);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(idx * 4); pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == CFG_KEY_ORDER) order_sel = v[0];
    endtask

    function automatic t_record rand_rec(bit narrow);
        t_record r;
        r.tag = 8'($urandom);
        if (narrow) begin
            r.ka = 16'($urandom_range(0, 3) - 2);
            r.kb = 16'($urandom_range(0, 3) - 2);
            r.kc = 16'($urandom_range(0, 3) - 2);
        end else begin
            r.ka = 16'($urandom); r.kb = 16'($urandom); r.kc = 16'($urandom);
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tuser[USER_VALID], o_m_tdata[7:0], o_m_tdata[23:8],
                    o_m_tdata[39:24], o_m_tdata[55:40], o_m_tuser[USER_OVERFLOW],
                    o_m_tdata[60:56]};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                exp_r = pending_q.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: mismatch exp %h got %h", $time, exp_r, got);
                    errors++;
                end
            end
        end
    end

    // receiver stalls and the long hold-off
    always @(negedge i_clk) begin
        if (hold_off) i_m_tready <= 1'b0;
        else if (!stall_en) i_m_tready <= 1'b1;
        else i_m_tready <= ($urandom_range(0, 9) > 2);
    end

    task automatic test_directed();
        t_record r;
        send_word(OP_POP, '0);
        r = '{8'hFF, 16'h7FFF, 16'h8000, 16'h0000};
        send_word(OP_PUSH, r);
        r = '{8'h00, 16'h8000, 16'h7FFF, 16'hFFFF};
        send_word(OP_PUSH, r);
        r = '{8'h55, 16'h8000, 16'h7FFF, 16'hFFFF};
        send_word(OP_PUSH, r);
        r = '{8'hAA, 16'h0001, 16'h8000, 16'h8000};
        send_word(OP_PUSH, r);
        repeat (5) send_word(OP_POP, '0);
        // fill to the brim then overflow
        for (int i = 0; i < DEPTH + 2; i++) send_word(OP_PUSH, rand_rec(i[0]));
        repeat (DEPTH + 1) send_word(OP_POP, '0);
    endtask

    task automatic test_random(int n);
        int lvl;
        lvl = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            if ((i % 60) == 0) lvl = $urandom_range(0, 2);
            if ($urandom_range(0, 9) < 4 + lvl * 2)
                send_word(OP_PUSH, rand_rec(1'($urandom_range(0, 1))));
            else send_word(OP_POP, rand_rec(1'b0));
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++) send_word(OP_PUSH, rand_rec(1'b1), 1'b0);
        join
        repeat (20) send_word(OP_POP, '0, 1'b0);
    endtask

    task automatic test_no_idle(int n);
        stall_en = 1'b0;
        for (int i = 0; i < n; i++)
            send_word(1'($urandom_range(0, 1)), rand_rec(1'($urandom_range(0, 1))), 1'b0);
        stall_en = 1'b1;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        write_reg(CFG_KEY_ORDER, ORDER_BCA);
        test_directed();
        test_random(400);
        write_reg(CFG_KEY_ORDER, ORDER_ABC);
        test_random(400);
        test_backpressure();
        write_reg(CFG_KEY_ORDER, 32'hFFFF_FFFF);
        test_random(350);
        test_no_idle(150);
        write_reg(CFG_KEY_ORDER, 32'h0);
        test_random(250);
        drain();
        if (errors == 0) $display("[multi_key_priority_queue] OK");
        else $display("[multi_key_priority_queue] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[multi_key_priority_queue] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/mkpq_pkg.sv
hdl/mkpq_ram.sv
hdl/mkpq_less.sv
hdl/multi_key_priority_queue.sv
tb/tb.sv
